// File: src/gpp_pkg.sv
// ----------------------------------------------------------------------------
// gpp_pkg
// Shared types, register indexes and byte constants for the gray pixel
// packetizer.
// ----------------------------------------------------------------------------
package gpp_pkg;

  // Defaults for top-level parameters
  localparam int COORD_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Configuration register indexes
  localparam int CFG_INDEX_BITS = 3;
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_FRAME_WIDTH   = 3'd0,
    CFG_FRAME_HEIGHT  = 3'd1,
    CFG_PACKET_SIZE   = 3'd2,
    CFG_COLOR_INPUT   = 3'd3,
    CFG_LITTLE_ENDIAN = 3'd4,
    CFG_DUPLICATE_LOW = 3'd5
  } cfg_index_t;

  // Register reset values
  localparam logic [15:0] FRAME_WIDTH_RST  = 16'd640;
  localparam logic [15:0] FRAME_HEIGHT_RST = 16'd480;
  localparam logic [15:0] PACKET_SIZE_RST  = 16'd0;

  // Stream constants
  localparam logic [7:0] HDR_MARK     = 8'h66;
  localparam logic [2:0] HDR_LAST_IDX = 3'd6;
  localparam logic [2:0] END_LAST_IDX = 3'd6;

  // Reciprocal of three: floor(sum * 683 / 2048) equals floor(sum / 3) for sum < 768
  localparam logic [9:0] THIRD_RECIP = 10'd683;
  localparam int         THIRD_SHIFT = 11;

  typedef struct packed {
    logic [15:0] frame_width;
    logic [15:0] frame_height;
    logic [15:0] packet_size;
    logic        color_input;
    logic        little_endian;
    logic        duplicate_low_byte;
  } cfg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       line_end;
    logic       frame_done;
    logic       last;
  } word_t;

  // One classified pixel, handed from front to back
  typedef struct packed {
    logic [7:0]  gray;
    logic        header;
    logic [15:0] count;
    logic        packet_end;
    logic        frame_end;
    logic        little_endian;
    logic        duplicate_low_byte;
  } job_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HDR,
    PH_PIX,
    PH_END
  } phase_t;

  // End-of-frame marker: 66 FF FF FF FF 00 00
  function automatic logic [7:0] end_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:                   b = HDR_MARK;
      3'd1, 3'd2, 3'd3, 3'd4: b = 8'hFF;
      default:                b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: src/gpp_front.sv
// ----------------------------------------------------------------------------
// gpp_front
// Accepts pixels, reduces them to gray, tracks frame and packet position and
// emits one classified job per pixel.
// ----------------------------------------------------------------------------
module gpp_front #(
  parameter int COORD_BITS = gpp_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  gpp_pkg::cfg_t         cfg,
  input  logic                  pixel_valid,
  input  gpp_pkg::pixel_t       pixel,
  input  logic                  queue_full,
  output logic                  push,
  output gpp_pkg::job_t         job,
  output logic [COORD_BITS-1:0] job_x,
  output logic [COORD_BITS-1:0] job_y
);

  logic [15:0] x_pos, x_pos_next;
  logic [15:0] y_pos, y_pos_next;
  logic [31:0] pixels_left, pixels_left_next;
  logic [15:0] left_in_packet, left_in_packet_next;

  logic        frame_start;
  logic [15:0] w, h, psize;
  logic [31:0] total, pl, pl_dec;
  logic [15:0] xs, ys, lip, lip_start, lip_dec, count;
  logic        hdr, frame_end, packet_end, wrap;
  logic [9:0]  sum;
  logic [18:0] prod;
  logic [7:0]  gray;

  assign push = pixel_valid && !queue_full;

  // Gray value by reciprocal multiply in color mode; red channel otherwise
  always_comb begin
    sum  = 10'(pixel.red) + 10'(pixel.green) + 10'(pixel.blue);
    prod = 19'(sum) * 19'(gpp_pkg::THIRD_RECIP);
    gray = cfg.color_input ? prod[18:gpp_pkg::THIRD_SHIFT] : pixel.red;
  end

  // Classify the pixel against frame and packet position
  always_comb begin
    w           = (cfg.frame_width == 16'd0) ? 16'd1 : cfg.frame_width;
    h           = (cfg.frame_height == 16'd0) ? 16'd1 : cfg.frame_height;
    total       = 32'(w) * 32'(h);
    frame_start = (pixels_left == 32'd0);
    pl          = frame_start ? total : pixels_left;
    xs          = frame_start ? 16'd0 : x_pos;
    ys          = frame_start ? 16'd0 : y_pos;
    lip         = frame_start ? 16'd0 : left_in_packet;
    hdr         = (lip == 16'd0);
    psize       = (cfg.packet_size == 16'd0) ? w : cfg.packet_size;
    count       = ({16'd0, psize} < pl) ? psize : pl[15:0];
    lip_start   = hdr ? count : lip;
    lip_dec     = lip_start - 16'd1;
    pl_dec      = pl - 32'd1;
    frame_end   = (pl_dec == 32'd0);
    packet_end  = (lip_dec == 16'd0) || frame_end;
    wrap        = (xs >= w - 16'd1);
  end

  // Next position
  always_comb begin
    if (frame_end) begin
      x_pos_next          = 16'd0;
      y_pos_next          = 16'd0;
      pixels_left_next    = 32'd0;
      left_in_packet_next = 16'd0;
    end else begin
      x_pos_next          = wrap ? 16'd0 : xs + 16'd1;
      y_pos_next          = wrap ? ys + 16'd1 : ys;
      pixels_left_next    = pl_dec;
      left_in_packet_next = lip_dec;
    end
  end

  // Advance position on each accepted pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      x_pos          <= 16'd0;
      y_pos          <= 16'd0;
      pixels_left    <= 32'd0;
      left_in_packet <= 16'd0;
    end else if (push) begin
      x_pos          <= x_pos_next;
      y_pos          <= y_pos_next;
      pixels_left    <= pixels_left_next;
      left_in_packet <= left_in_packet_next;
    end
  end

  // Build the job word
  always_comb begin
    job.gray               = gray;
    job.header             = hdr;
    job.count              = count;
    job.packet_end         = packet_end;
    job.frame_end          = frame_end;
    job.little_endian      = cfg.little_endian;
    job.duplicate_low_byte = cfg.duplicate_low_byte;
    job_x                  = xs[COORD_BITS-1:0];
    job_y                  = ys[COORD_BITS-1:0];
  end

endmodule

// File: src/gpp_queue.sv
// ----------------------------------------------------------------------------
// gpp_queue
// Short register queue holding classified jobs between front and back.
// ----------------------------------------------------------------------------
module gpp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = gpp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             full,
  output logic             empty
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
  localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

  logic [WIDTH-1:0]    entries [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [CNT_BITS-1:0] fill;

  assign full  = (fill == CNT_FULL);
  assign empty = (fill == '0);
  assign head  = entries[rd_ptr];

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// File: src/gpp_back.sv
// ----------------------------------------------------------------------------
// gpp_back
// Expands each job into header, pixel and end-marker words, one word per
// cycle while the stream is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module gpp_back #(
  parameter int COORD_BITS = gpp_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  gpp_pkg::job_t         head,
  input  logic [COORD_BITS-1:0] head_x,
  input  logic [COORD_BITS-1:0] head_y,
  input  logic                  queue_empty,
  output logic                  pop,
  output logic                  stream_valid,
  input  logic                  stream_stall,
  output gpp_pkg::word_t        stream_word
);

  gpp_pkg::phase_t       phase, phase_next, eff_phase;
  logic [2:0]            idx, idx_next, eff_idx;
  gpp_pkg::job_t         cur, eff_job;
  logic [COORD_BITS-1:0] cur_x, cur_y, eff_x, eff_y;
  logic                  have, load, fire;
  logic [15:0]           hval;
  gpp_pkg::word_t        word_next;

  // Select the job at work: the held one, or the queue head when idle
  always_comb begin
    if (phase == gpp_pkg::PH_IDLE) begin
      eff_job   = head;
      eff_x     = head_x;
      eff_y     = head_y;
      eff_phase = head.header ? gpp_pkg::PH_HDR : gpp_pkg::PH_PIX;
      eff_idx   = 3'd0;
      have      = !queue_empty;
    end else begin
      eff_job   = cur;
      eff_x     = cur_x;
      eff_y     = cur_y;
      eff_phase = phase;
      eff_idx   = idx;
      have      = 1'b1;
    end
  end

  assign load = !stream_valid || !stream_stall;
  assign fire = have && load;
  assign pop  = fire && (phase == gpp_pkg::PH_IDLE);

  // Next state
  always_comb begin
    phase_next = phase;
    idx_next   = idx;
    if (fire) begin
      unique case (eff_phase)
        gpp_pkg::PH_HDR: begin
          if (eff_idx == gpp_pkg::HDR_LAST_IDX) begin
            phase_next = gpp_pkg::PH_PIX;
            idx_next   = 3'd0;
          end else begin
            phase_next = gpp_pkg::PH_HDR;
            idx_next   = eff_idx + 3'd1;
          end
        end
        gpp_pkg::PH_PIX: begin
          if (eff_idx == 3'd0) begin
            phase_next = gpp_pkg::PH_PIX;
            idx_next   = 3'd1;
          end else begin
            phase_next = eff_job.frame_end ? gpp_pkg::PH_END : gpp_pkg::PH_IDLE;
            idx_next   = 3'd0;
          end
        end
        gpp_pkg::PH_END: begin
          if (eff_idx == gpp_pkg::END_LAST_IDX) begin
            phase_next = gpp_pkg::PH_IDLE;
            idx_next   = 3'd0;
          end else begin
            phase_next = gpp_pkg::PH_END;
            idx_next   = eff_idx + 3'd1;
          end
        end
        default: begin
          phase_next = phase;
          idx_next   = idx;
        end
      endcase
    end
  end

  // Word contents for the current position
  always_comb begin
    unique case (eff_idx)
      3'd1, 3'd2: hval = 16'(eff_x);
      3'd3, 3'd4: hval = 16'(eff_y);
      default:    hval = eff_job.count;
    endcase
    word_next = '0;
    unique case (eff_phase)
      gpp_pkg::PH_HDR: begin
        if (eff_idx == 3'd0) begin
          word_next.out_byte = gpp_pkg::HDR_MARK;
        end else if (eff_idx[0] ^ eff_job.little_endian) begin
          word_next.out_byte = hval[15:8];
        end else begin
          word_next.out_byte = hval[7:0];
        end
      end
      gpp_pkg::PH_PIX: begin
        if (eff_idx == 3'd0) begin
          word_next.out_byte = (eff_job.duplicate_low_byte || eff_job.little_endian)
                             ? eff_job.gray : 8'd0;
        end else begin
          word_next.out_byte = (eff_job.duplicate_low_byte || !eff_job.little_endian)
                             ? eff_job.gray : 8'd0;
          word_next.line_end = eff_job.packet_end;
          word_next.last     = !eff_job.frame_end;
        end
      end
      gpp_pkg::PH_END: begin
        word_next.out_byte = gpp_pkg::end_byte(eff_idx);
        if (eff_idx == gpp_pkg::END_LAST_IDX) begin
          word_next.line_end   = 1'b1;
          word_next.frame_done = 1'b1;
          word_next.last       = 1'b1;
        end
      end
      default: word_next = '0;
    endcase
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= gpp_pkg::PH_IDLE;
      idx   <= 3'd0;
    end else begin
      phase <= phase_next;
      idx   <= idx_next;
    end
  end

  // Hold the job taken from the queue
  always_ff @(posedge clk) begin
    if (pop) begin
      cur   <= head;
      cur_x <= head_x;
      cur_y <= head_y;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      stream_valid <= 1'b0;
    end else if (load) begin
      stream_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      stream_word <= word_next;
    end
  end

endmodule

// File: src/gray_pixel_packetizer.sv
// ----------------------------------------------------------------------------
// gray_pixel_packetizer
// Turns a pixel stream into a packetized gray byte stream with headers and an
// end-of-frame marker.
// ----------------------------------------------------------------------------
// Usage:
//   pixel channel (pixel_valid / pixel_stall / pixel) takes one RGB or gray
//   pixel per word. stream channel (stream_valid / stream_stall / stream_word)
//   gives one byte per word with line_end, frame_done and last flags.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes the
//   frame width, height, packet size and mode bits; it is always ready.
//   Throughput: the output side delivers one byte per cycle while stream_stall
//   is low; a pixel gives two bytes, nine when it opens a packet (seven header
//   bytes), plus seven end-of-frame marker bytes after the last pixel of a frame.
//   Latency: a taken pixel is registered in the job queue and then in the
//   output register before its first byte is valid on the stream channel;
//   when the back end is busy, it follows the last word still ahead of it.
//   A two-entry job queue sits between the pixel front end and the byte
//   sequencer; pixel_stall rises only when that queue is full, so a stalled
//   receiver backs up into the queue and then into the pixel channel.
//   Reset clears position counters, the queue and the output register and
//   loads the registers with 640 x 480, row-sized packets, color input,
//   big-endian order and zero padding.
// ----------------------------------------------------------------------------
module gray_pixel_packetizer #(
  parameter int COORD_BITS  = gpp_pkg::COORD_BITS_DEF,
  parameter int QUEUE_DEPTH = gpp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                pixel_valid,
  output logic                                pixel_stall,
  input  gpp_pkg::pixel_t                     pixel,
  output logic                                stream_valid,
  input  logic                                stream_stall,
  output gpp_pkg::word_t                      stream_word,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gpp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [15:0]                         cfg_data
);

  localparam int QW = $bits(gpp_pkg::job_t) + 2 * COORD_BITS;

  gpp_pkg::cfg_t         cfg;
  logic                  push, pop, queue_full, queue_empty;
  gpp_pkg::job_t         job, head_job;
  logic [COORD_BITS-1:0] job_x, job_y, head_x, head_y;
  logic [QW-1:0]         head_word;

  assign cfg_ready   = 1'b1;
  assign pixel_stall = queue_full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width        <= gpp_pkg::FRAME_WIDTH_RST;
      cfg.frame_height       <= gpp_pkg::FRAME_HEIGHT_RST;
      cfg.packet_size        <= gpp_pkg::PACKET_SIZE_RST;
      cfg.color_input        <= 1'b1;
      cfg.little_endian      <= 1'b0;
      cfg.duplicate_low_byte <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gpp_pkg::CFG_FRAME_WIDTH:   cfg.frame_width        <= cfg_data;
        gpp_pkg::CFG_FRAME_HEIGHT:  cfg.frame_height       <= cfg_data;
        gpp_pkg::CFG_PACKET_SIZE:   cfg.packet_size        <= cfg_data;
        gpp_pkg::CFG_COLOR_INPUT:   cfg.color_input        <= cfg_data[0];
        gpp_pkg::CFG_LITTLE_ENDIAN: cfg.little_endian      <= cfg_data[0];
        gpp_pkg::CFG_DUPLICATE_LOW: cfg.duplicate_low_byte <= cfg_data[0];
        default: ;
      endcase
    end
  end

  gpp_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .pixel_valid (pixel_valid),
    .pixel       (pixel),
    .queue_full  (queue_full),
    .push        (push),
    .job         (job),
    .job_x       (job_x),
    .job_y       (job_y)
  );

  gpp_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({job, job_x, job_y}),
    .pop       (pop),
    .head      (head_word),
    .full      (queue_full),
    .empty     (queue_empty)
  );

  assign {head_job, head_x, head_y} = head_word;

  gpp_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head_job),
    .head_x       (head_x),
    .head_y       (head_y),
    .queue_empty  (queue_empty),
    .pop          (pop),
    .stream_valid (stream_valid),
    .stream_stall (stream_stall),
    .stream_word  (stream_word)
  );

endmodule

// File: tb/sv/gray_pixel_packetizer_checker.sv
// ----------------------------------------------------------------------------
// gray_pixel_packetizer_checker
// Watches the pixel, stream and register channels of the packetizer, builds
// the byte stream that each accepted pixel must produce and compares every
// accepted stream word against it, field by field.
// ----------------------------------------------------------------------------
module gray_pixel_packetizer_checker
  import gpp_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      pixel_valid,
  input  logic                      pixel_stall,
  input  pixel_t                    pixel,
  input  logic                      stream_valid,
  input  logic                      stream_stall,
  input  word_t                     stream_word,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [15:0]               cfg_data,
  output int                        mismatches,
  output int                        words_pending,
  output logic [31:0]               frame_pixels_left
);

  localparam int          MAX_REPORTS   = 10;
  localparam logic [55:0] FRAME_TRAILER = 56'h66_FF_FF_FF_FF_00_00;
  localparam logic [15:0] COORD_MASK    = 16'((32'd1 << COORD_BITS) - 1);

  // Shadow registers and stream position
  cfg_t        regs;
  logic [15:0] col;
  logic [15:0] row;
  logic [15:0] packet_left;
  logic [31:0] frame_left;
  word_t       byte_q[$];
  int          errors = 0;
  int          word_no = 0;

  function automatic void push_byte(input logic [7:0] b, input logic le, input logic fd);
    word_t w;
    w.out_byte   = b;
    w.line_end   = le;
    w.frame_done = fd;
    w.last       = 1'b0;
    byte_q.push_back(w);
  endfunction

  // Queue a 16-bit header field in the current byte order
  function automatic void push_half(input logic [15:0] v);
    if (regs.little_endian) begin
      push_byte(v[7:0], 1'b0, 1'b0);
      push_byte(v[15:8], 1'b0, 1'b0);
    end else begin
      push_byte(v[15:8], 1'b0, 1'b0);
      push_byte(v[7:0], 1'b0, 1'b0);
    end
  endfunction

  // Queue every word that one pixel produces and advance the position
  task automatic predict_pixel_bytes(input pixel_t px);
    logic [15:0] w;
    logic [15:0] h;
    logic [15:0] psize;
    logic [31:0] count;
    logic [9:0]  sum;
    logic [7:0]  gray;
    logic        pkt_end;
    logic        frm_end;
    word_t       tail;
    w = (regs.frame_width == 16'd0) ? 16'd1 : regs.frame_width;
    h = (regs.frame_height == 16'd0) ? 16'd1 : regs.frame_height;
    sum = 10'(px.red) + 10'(px.green) + 10'(px.blue);
    gray = regs.color_input ? 8'(sum / 10'd3) : px.red;

    // open a new frame; its length stays fixed until it ends
    if (frame_left == 32'd0) begin
      frame_left  = 32'(w) * 32'(h);
      col         = '0;
      row         = '0;
      packet_left = '0;
    end

    if (packet_left == 16'd0) begin
      psize = (regs.packet_size == 16'd0) ? w : regs.packet_size;
      count = (32'(psize) < frame_left) ? 32'(psize) : frame_left;
      push_byte(HDR_MARK, 1'b0, 1'b0);
      push_half(col & COORD_MASK);
      push_half(row & COORD_MASK);
      push_half(count[15:0]);
      packet_left = count[15:0];
    end

    packet_left = packet_left - 16'd1;
    frame_left  = frame_left - 32'd1;
    frm_end     = (frame_left == 32'd0);
    pkt_end     = (packet_left == 16'd0) || frm_end;

    if (regs.duplicate_low_byte) begin
      push_byte(gray, 1'b0, 1'b0);
      push_byte(gray, pkt_end, 1'b0);
    end else if (regs.little_endian) begin
      push_byte(gray, 1'b0, 1'b0);
      push_byte(8'h00, pkt_end, 1'b0);
    end else begin
      push_byte(8'h00, 1'b0, 1'b0);
      push_byte(gray, pkt_end, 1'b0);
    end

    // wrap the row, also when a narrower width arrived mid-frame
    if (col >= w - 16'd1) begin
      col = '0;
      row = row + 16'd1;
    end else begin
      col = col + 16'd1;
    end

    if (frm_end) begin
      for (int i = 0; i < 7; i++) begin
        push_byte(FRAME_TRAILER[55-8*i -: 8], i == 6, i == 6);
      end
      col         = '0;
      row         = '0;
      packet_left = '0;
    end

    // flag the final word of this pixel
    tail = byte_q.pop_back();
    tail.last = 1'b1;
    byte_q.push_back(tail);
  endtask

  always @(posedge clk) begin
    word_t want;
    if (rst) begin
      regs.frame_width        = FRAME_WIDTH_RST;
      regs.frame_height       = FRAME_HEIGHT_RST;
      regs.packet_size        = PACKET_SIZE_RST;
      regs.color_input        = 1'b1;   // color input, big-endian, zero padding
      regs.little_endian      = 1'b0;
      regs.duplicate_low_byte = 1'b0;
      col         = '0;
      row         = '0;
      packet_left = '0;
      frame_left  = '0;
      byte_q.delete();
    end else begin
      // apply register writes at once
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FRAME_WIDTH:   regs.frame_width        = cfg_data;
          CFG_FRAME_HEIGHT:  regs.frame_height       = cfg_data;
          CFG_PACKET_SIZE:   regs.packet_size        = cfg_data;
          CFG_COLOR_INPUT:   regs.color_input        = cfg_data[0];
          CFG_LITTLE_ENDIAN: regs.little_endian      = cfg_data[0];
          CFG_DUPLICATE_LOW: regs.duplicate_low_byte = cfg_data[0];
          default: ;
        endcase
      end

      if (pixel_valid && !pixel_stall) begin
        predict_pixel_bytes(pixel);
      end

      // compare each accepted word with the oldest expected one
      if (stream_valid && !stream_stall) begin
        if (byte_q.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("checker: word %0d arrived with none expected: byte %02h le %0b fd %0b last %0b",
                     word_no, stream_word.out_byte, stream_word.line_end,
                     stream_word.frame_done, stream_word.last);
          end
        end else begin
          want = byte_q.pop_front();
          if (stream_word.out_byte !== want.out_byte || stream_word.line_end !== want.line_end ||
              stream_word.frame_done !== want.frame_done || stream_word.last !== want.last) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
              $display("checker: word %0d expected byte %02h le %0b fd %0b last %0b, got byte %02h le %0b fd %0b last %0b",
                       word_no, want.out_byte, want.line_end, want.frame_done, want.last,
                       stream_word.out_byte, stream_word.line_end, stream_word.frame_done,
                       stream_word.last);
            end
          end
        end
        word_no++;
      end
    end
    mismatches        <= errors;
    words_pending     <= byte_q.size();
    frame_pixels_left <= frame_left;
  end

endmodule

// File: tb/sv/gray_pixel_packetizer_tb.sv
// ----------------------------------------------------------------------------
// gray_pixel_packetizer_tb
// Drives pixels and register writes into the packetizer with random gaps and
// output stalls, directed corner cases first and random frames after; a
// checker beside the block predicts and compares the byte stream.
// ----------------------------------------------------------------------------
module gray_pixel_packetizer_tb;
  import gpp_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int TAIL_CYCLES  = 20;
  localparam int RANDOM_ITEMS = 185;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_HI = 3'd7;

  logic                      clk;
  logic                      rst;
  logic                      pixel_valid;
  logic                      pixel_stall;
  pixel_t                    pixel;
  logic                      stream_valid;
  logic                      stream_stall;
  word_t                     stream_word;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [15:0]               cfg_data;

  int          fail_count;
  int          words_pending;
  logic [31:0] frame_pixels_left;
  bit          tx_idle;
  bit          rx_idle;
  int          cycle_count = 0;

  gray_pixel_packetizer u_top (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .stream_valid (stream_valid),
    .stream_stall (stream_stall),
    .stream_word  (stream_word),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  gray_pixel_packetizer_checker u_check (
    .clk               (clk),
    .rst               (rst),
    .pixel_valid       (pixel_valid),
    .pixel_stall       (pixel_stall),
    .pixel             (pixel),
    .stream_valid      (stream_valid),
    .stream_stall      (stream_stall),
    .stream_word       (stream_word),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .mismatches        (fail_count),
    .words_pending     (words_pending),
    .frame_pixels_left (frame_pixels_left)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Stall the stream side at random before each word while rx_idle is set
  initial begin
    int hold;
    stream_stall = 1'b0;
    forever begin
      @(negedge clk);
      hold = rx_idle ? $urandom_range(0, 17) : 0;
      if (hold > 0) begin
        stream_stall = 1'b1;
        repeat (hold) @(negedge clk);
      end
      stream_stall = 1'b0;
      do @(posedge clk); while (!stream_valid);
    end
  end

  // Bound the run
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  function automatic pixel_t rgb(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    pixel_t p;
    p.red   = r;
    p.green = g;
    p.blue  = b;
    return p;
  endfunction

  function automatic logic [15:0] pick_side(input int top);
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'd1;
      default: return 16'($urandom_range(1, top));
    endcase
  endfunction

  // Send one pixel word after an optional gap; called at a falling edge
  task automatic push_pixel(input pixel_t px);
    int gap;
    gap = tx_idle ? $urandom_range(0, 17) : 0;
    repeat (gap) @(negedge clk);
    pixel_valid = 1'b1;
    pixel       = px;
    do @(posedge clk); while (pixel_stall);
    @(negedge clk);
    pixel_valid = 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [15:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Hold until every expected word has come out
  task automatic wait_drained();
    while (words_pending != 0) @(negedge clk);
  endtask

  task automatic load_setup(input logic [15:0] w, input logic [15:0] h, input logic [15:0] ps,
                            input bit color, input bit le, input bit dup);
    wait_drained();
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    write_reg(CFG_PACKET_SIZE, ps);
    write_reg(CFG_COLOR_INPUT, {15'd0, color});
    write_reg(CFG_LITTLE_ENDIAN, {15'd0, le});
    write_reg(CFG_DUPLICATE_LOW, {15'd0, dup});
  endtask

  initial begin
    int  sent;
    int  n;
    bit  paused;
    logic [15:0] ps;
    rst         = 1'b1;
    pixel_valid = 1'b0;
    pixel       = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    tx_idle     = 1'b1;
    rx_idle     = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // 3x2 frame, other registers left at their reset values
    write_reg(CFG_FRAME_WIDTH, 16'd3);
    write_reg(CFG_FRAME_HEIGHT, 16'd2);
    push_pixel(rgb(8'h00, 8'h00, 8'h00));
    push_pixel(rgb(8'hFF, 8'hFF, 8'hFF));
    push_pixel(rgb(8'hFF, 8'hFF, 8'hFE));
    push_pixel(rgb(8'h02, 8'h00, 8'h00));
    push_pixel(rgb(8'h01, 8'h01, 8'h01));
    push_pixel(rgb(8'h64, 8'h32, 8'h03));

    // one-pixel frames, gray input, low byte first
    load_setup(16'd1, 16'd1, 16'd0, 1'b0, 1'b1, 1'b0);
    push_pixel(rgb(8'hFF, 8'h12, 8'h34));
    push_pixel(rgb(8'h00, 8'hFF, 8'hFF));
    push_pixel(rgb(8'hA5, 8'h5A, 8'h00));

    // zero width and height act as one; duplicate mode; ignored indexes
    load_setup(16'd0, 16'd0, 16'd1, 1'b1, 1'b0, 1'b1);
    write_reg(CFG_SPARE_LO, 16'hFFFF);
    write_reg(CFG_SPARE_HI, 16'hFFFF);
    push_pixel(rgb(8'h80, 8'h80, 8'h7F));
    push_pixel(rgb(8'h7F, 8'h00, 8'hFF));

    // oversized packet clamps to the frame; narrow the rows mid-frame
    load_setup(16'd4, 16'd3, 16'hFFFF, 1'b1, 1'b1, 1'b1);
    for (int i = 0; i < 5; i++) push_pixel(pixel_t'($urandom));
    load_setup(16'd2, 16'd3, 16'd1, 1'b1, 1'b1, 1'b0);
    for (int i = 0; i < 7; i++) push_pixel(pixel_t'($urandom));

    // random setups over small frames
    sent   = 0;
    paused = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 7))
        0:       ps = 16'd0;
        1:       ps = 16'hFFFF;
        2:       ps = 16'($urandom_range(7, 65534));
        default: ps = 16'($urandom_range(1, 8));
      endcase
      load_setup(pick_side(6), pick_side(4), ps, 1'($urandom), 1'($urandom), 1'($urandom));
      if ($urandom_range(0, 5) == 0) write_reg(CFG_SPARE_LO, 16'($urandom));
      n = $urandom_range(4, 24);
      for (int i = 0; i < n; i++) begin
        // let the stream run dry in the middle of a phase
        if (i == n / 2 && (!paused || $urandom_range(0, 3) == 0)) begin
          wait_drained();
          paused = 1'b1;
        end
        push_pixel(pixel_t'($urandom));
      end
      sent += n;
    end

    // finish the open frame, then start the largest one
    while (frame_pixels_left != 32'd0) push_pixel(pixel_t'($urandom));
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    load_setup(16'hFFFF, 16'hFFFF, 16'd0, 1'b1, 1'b0, 1'b0);
    for (int i = 0; i < 8; i++) push_pixel(pixel_t'($urandom));

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && words_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
